### rtl/sdtq_pkg.sv
`timescale 1ns / 1ps
package sdtq_pkg;
  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 31;
  localparam int ID_BITS    = 4;
  localparam int SLOT_BITS  = $clog2(NUM_TIMERS);

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_ARM    = 3'd1,
    CMD_CANCEL = 3'd2,
    CMD_CLONE  = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_TICK,
    ST_RESP
  } state_t;

  // operation applied to every cell of the order chain
  typedef enum logic [1:0] {
    OP_NONE,
    OP_REMOVE,
    OP_INSERT,
    OP_POP
  } chain_op_t;
endpackage

### rtl/sdtq_cell.sv
`timescale 1ns / 1ps
// One queue position: holds a slot id and its deadline, shifts with neighbors.
module sdtq_cell #(
  parameter int ID_BITS   = 4,
  parameter int TIME_BITS = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sdtq_pkg::chain_op_t  op,
  input  logic                 occ_left,
  input  logic [ID_BITS-1:0]   id_left,
  input  logic [TIME_BITS-1:0] dl_left,
  input  logic                 go_left,
  input  logic                 occ_right,
  input  logic [ID_BITS-1:0]   id_right,
  input  logic [TIME_BITS-1:0] dl_right,
  input  logic [ID_BITS-1:0]   key_id,
  input  logic [TIME_BITS-1:0] key_dl,
  input  logic                 after_src,
  input  logic                 by_src,
  output logic                 occ,
  output logic [ID_BITS-1:0]   id,
  output logic [TIME_BITS-1:0] dl,
  output logic                 go
);
  logic                 occ_r, occ_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [TIME_BITS-1:0] dl_r, dl_nxt;
  logic                 match, here;

  // go: insertion point reached at or before this cell
  assign match = occ_r && (id_r == key_id);
  assign here  = by_src ? after_src : (!occ_r || (dl_r > key_dl));
  assign go    = go_left || here;

  always_comb begin
    occ_nxt = occ_r;
    id_nxt  = id_r;
    dl_nxt  = dl_r;
    unique case (op)
      sdtq_pkg::OP_REMOVE: begin
        if (go_left || match) begin
          occ_nxt = occ_right;
          id_nxt  = id_right;
          dl_nxt  = dl_right;
        end
      end
      sdtq_pkg::OP_INSERT: begin
        if (go_left) begin
          occ_nxt = occ_left;
          id_nxt  = id_left;
          dl_nxt  = dl_left;
        end else if (here) begin
          occ_nxt = 1'b1;
          id_nxt  = key_id;
          dl_nxt  = key_dl;
        end
      end
      sdtq_pkg::OP_POP: begin
        occ_nxt = occ_right;
        id_nxt  = id_right;
        dl_nxt  = dl_right;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
    id_r <= id_nxt;
    dl_r <= dl_nxt;
  end

  assign occ = occ_r;
  assign id  = id_r;
  assign dl  = dl_r;
endmodule

### rtl/sdtq_chain.sv
`timescale 1ns / 1ps
// Row of cells: the sorted order list; head is cell 0.
module sdtq_chain #(
  parameter int NUM_TIMERS = 16,
  parameter int ID_BITS    = 4,
  parameter int TIME_BITS  = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sdtq_pkg::chain_op_t  op,
  input  logic [ID_BITS-1:0]   key_id,
  input  logic [TIME_BITS-1:0] key_dl,
  input  logic [ID_BITS-1:0]   src_id,
  input  logic                 by_src,
  output logic                 head_occ,
  output logic [ID_BITS-1:0]   head_id,
  output logic [TIME_BITS-1:0] head_dl
);
  logic                 occ [NUM_TIMERS];
  logic [ID_BITS-1:0]   ids [NUM_TIMERS];
  logic [TIME_BITS-1:0] dls [NUM_TIMERS];
  logic                 go  [NUM_TIMERS];
  logic                 go_in [NUM_TIMERS];
  logic                 after [NUM_TIMERS];

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic                 ol, orr;
    logic [ID_BITS-1:0]   il, ir;
    logic [TIME_BITS-1:0] dlft, drt;
    if (i == 0) begin : g_first
      assign ol = 1'b0; assign il = '0; assign dlft = '0;
      assign go_in[i] = 1'b0;
      assign after[i] = 1'b0;
    end else begin : g_mid
      assign ol = occ[i-1]; assign il = ids[i-1]; assign dlft = dls[i-1];
      // remove: shift once the removed id is found upstream
      assign go_in[i] = (op == sdtq_pkg::OP_REMOVE)
                        ? (go_in[i-1] || (occ[i-1] && ids[i-1] == key_id))
                        : go[i-1];
      assign after[i] = occ[i-1] && (ids[i-1] == src_id);
    end
    if (i == NUM_TIMERS - 1) begin : g_last
      assign orr = 1'b0; assign ir = '0; assign drt = '0;
    end else begin : g_inner
      assign orr = occ[i+1]; assign ir = ids[i+1]; assign drt = dls[i+1];
    end
    sdtq_cell #(.ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)) u_cell (
      .clk, .rst_n, .op,
      .occ_left(ol), .id_left(il), .dl_left(dlft), .go_left(go_in[i]),
      .occ_right(orr), .id_right(ir), .dl_right(drt),
      .key_id, .key_dl,
      .after_src(after[i]), .by_src,
      .occ(occ[i]), .id(ids[i]), .dl(dls[i]), .go(go[i])
    );
  end

  assign head_occ = occ[0];
  assign head_id  = ids[0];
  assign head_dl  = dls[0];
endmodule

### rtl/sorted_deadline_timer_queue_core.sv
`timescale 1ns / 1ps
// Sorted deadline timer queue.
// Input channel (in_valid/in_ready) takes one command word: tick, arm,
// cancel, clone or query. Output channel (out_valid/out_ready) returns
// result words; out_last marks the final word of a command.
// The order list is a row of cells, each holding one queued slot id and
// its deadline; a chain operation (remove, insert, pop) shifts all
// cells at once, so an edit is a single chain operation.
// Query, cancel and a clone that inserts nothing pass through the
// remove and response states; arm and a clone that inserts pass through
// remove, insert and response. A tick emits one expiry word per cycle
// while the head is due and the output is not stalled; a tick with
// nothing due gives no word. One command is in flight at a time;
// in_ready is high only when idle, and the serial edit sequence returns
// to idle before the next command is taken.
// Reset clears active marks, the cell occupancy and the control FSM;
// deadlines and ids need no reset. When out_ready is low the output
// register holds and the sequencer waits; nothing is lost.
module sorted_deadline_timer_queue_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [3:0]  in_timer_id,
  input  logic [3:0]  in_source_id,
  input  logic [30:0] in_deadline,
  input  logic [30:0] in_now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_slot_id,
  output logic        out_kind,
  output logic        out_is_active,
  output logic        out_error,
  output logic        out_last
);
  localparam int NUM_TIMERS = sdtq_pkg::NUM_TIMERS;
  localparam int TIME_BITS  = sdtq_pkg::TIME_BITS;
  localparam int ID_BITS    = sdtq_pkg::ID_BITS;
  localparam int SB         = sdtq_pkg::SLOT_BITS;

  sdtq_pkg::state_t state_r, state_nxt;
  logic [2:0]           cmd_r;
  logic [3:0]           tid_r, sid_r;
  logic [TIME_BITS-1:0] when_r, now_r;
  logic [NUM_TIMERS-1:0] active_r;
  logic [TIME_BITS-1:0]  sdl_r [NUM_TIMERS]; // slot deadlines (no reset)

  logic                 ov_r;
  logic [3:0]           oid_r;
  logic                 okind_r, oact_r, oerr_r, olast_r;
  logic                 load_o;
  logic                 errflag_r;

  sdtq_pkg::chain_op_t  op;
  logic [ID_BITS-1:0]   key_id, src_id;
  logic [TIME_BITS-1:0] key_dl;
  logic                 by_src;
  logic                 head_occ;
  logic [ID_BITS-1:0]   head_id;
  logic [TIME_BITS-1:0] head_dl;

  logic tid_ok, sid_ok, d_act, s_act, out_free, due;
  logic [SB-1:0] d_ix, s_ix;

  assign tid_ok = ({1'b0, tid_r} < 5'(NUM_TIMERS));
  assign sid_ok = ({1'b0, sid_r} < 5'(NUM_TIMERS));
  assign d_ix   = tid_r[SB-1:0];
  assign s_ix   = sid_r[SB-1:0];
  assign d_act  = tid_ok && active_r[d_ix];
  assign s_act  = sid_ok && active_r[s_ix];
  assign out_free = !ov_r || out_ready;
  assign due    = head_occ && (head_dl <= now_r);
  assign in_ready = (state_r == sdtq_pkg::ST_IDLE);
  // output register loads on a pop or a status word
  assign load_o = (state_r == sdtq_pkg::ST_TICK && op == sdtq_pkg::OP_POP) ||
                  (state_r == sdtq_pkg::ST_RESP && out_free);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sdtq_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == sdtq_pkg::CMD_TICK) state_nxt = sdtq_pkg::ST_TICK;
          else state_nxt = sdtq_pkg::ST_REMOVE;
        end
      end
      sdtq_pkg::ST_REMOVE: begin
        priority if (!tid_ok) state_nxt = sdtq_pkg::ST_RESP;
        else if (cmd_r == sdtq_pkg::CMD_ARM) state_nxt = sdtq_pkg::ST_INSERT;
        else if (cmd_r == sdtq_pkg::CMD_CLONE && sid_ok && !d_act && s_act)
          state_nxt = sdtq_pkg::ST_INSERT;
        else state_nxt = sdtq_pkg::ST_RESP;
      end
      sdtq_pkg::ST_INSERT: state_nxt = sdtq_pkg::ST_RESP;
      sdtq_pkg::ST_TICK: begin
        if (!due) state_nxt = sdtq_pkg::ST_IDLE;
      end
      sdtq_pkg::ST_RESP: begin
        if (out_free) state_nxt = sdtq_pkg::ST_IDLE;
      end
      default: state_nxt = sdtq_pkg::ST_IDLE;
    endcase
  end

  // chain control
  always_comb begin
    op     = sdtq_pkg::OP_NONE;
    key_id = ID_BITS'(tid_r);
    key_dl = when_r;
    src_id = ID_BITS'(sid_r);
    by_src = 1'b0;
    unique case (state_r)
      sdtq_pkg::ST_REMOVE: begin
        if (tid_ok && d_act &&
            (cmd_r == sdtq_pkg::CMD_ARM || cmd_r == sdtq_pkg::CMD_CANCEL))
          op = sdtq_pkg::OP_REMOVE;
      end
      sdtq_pkg::ST_INSERT: begin
        op = sdtq_pkg::OP_INSERT;
        if (cmd_r == sdtq_pkg::CMD_CLONE) begin
          by_src = 1'b1;
          key_dl = sdl_r[s_ix];
        end
      end
      sdtq_pkg::ST_TICK: begin
        if (due && out_free) op = sdtq_pkg::OP_POP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sdtq_pkg::ST_IDLE;
      active_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_o) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (state_r)
        sdtq_pkg::ST_REMOVE: begin
          if (tid_ok && cmd_r == sdtq_pkg::CMD_CANCEL) active_r[d_ix] <= 1'b0;
          if (tid_ok && cmd_r == sdtq_pkg::CMD_ARM) begin
            active_r[d_ix] <= 1'b1;
            sdl_r[d_ix]    <= when_r;
          end
        end
        sdtq_pkg::ST_INSERT: begin
          if (cmd_r == sdtq_pkg::CMD_CLONE) begin
            active_r[d_ix] <= 1'b1;
            sdl_r[d_ix]    <= sdl_r[s_ix];
          end
        end
        sdtq_pkg::ST_TICK: begin
          if (op == sdtq_pkg::OP_POP) begin
            active_r[head_id[SB-1:0]] <= 1'b0;
            oid_r   <= 4'(head_id);
            okind_r <= 1'b0;
            oact_r  <= 1'b0;
            oerr_r  <= 1'b0;
            // cleared on a pop; out_last then follows whether the next head is due
            olast_r <= 1'b0;
          end else if (!due && ov_r && !out_ready) begin
            olast_r <= 1'b1;
          end else if (!due && ov_r && out_ready) begin
            olast_r <= olast_r;
          end
        end
        sdtq_pkg::ST_RESP: begin
          if (out_free) begin
            oid_r   <= tid_r;
            okind_r <= 1'b1;
            olast_r <= 1'b1;
            if (!tid_ok || (cmd_r == sdtq_pkg::CMD_CLONE && !sid_ok)) begin
              oact_r <= 1'b0;
              oerr_r <= 1'b0;
            end else if (cmd_r == sdtq_pkg::CMD_CLONE && errflag_r) begin
              oact_r <= 1'b1;
              oerr_r <= 1'b1;
            end else begin
              oact_r <= active_r[d_ix];
              oerr_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // clone error captured before the insert changes the destination mark
  always_ff @(posedge clk) begin
    if (state_r == sdtq_pkg::ST_REMOVE) errflag_r <= d_act;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      tid_r  <= in_timer_id;
      sid_r  <= in_source_id;
      when_r <= TIME_BITS'(in_deadline);
      now_r  <= TIME_BITS'(in_now_time);
    end
  end

  sdtq_chain #(
    .NUM_TIMERS(NUM_TIMERS), .ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)
  ) u_chain (
    .clk, .rst_n, .op, .key_id, .key_dl, .src_id, .by_src,
    .head_occ, .head_id, .head_dl
  );

  // a pop's last flag: the word is final if the following head is not due
  logic pop_hold_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pop_hold_r <= 1'b0;
    else pop_hold_r <= (op == sdtq_pkg::OP_POP);
  end

  assign out_valid     = ov_r;
  assign out_slot_id   = oid_r;
  assign out_kind      = okind_r;
  assign out_is_active = oact_r;
  assign out_error     = oerr_r;
  // after a pop the new head is visible; last if it is not due
  assign out_last      = okind_r ? olast_r
                       : (pop_hold_r ? !due
                          : (olast_r || state_r != sdtq_pkg::ST_TICK || !due));
endmodule

### rtl/sdtq_checker.sv
`timescale 1ns / 1ps
module sdtq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_slot_id,
  input logic       out_kind,
  input logic       out_is_active,
  input logic       out_error
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot_id))
    else $error("result word dropped under stall");
  a_exp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> !out_is_active && !out_error)
    else $error("expiry word with status bits");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_is_active && out_kind)
    else $error("clone error without active mark");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in flight");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind sorted_deadline_timer_queue_core sdtq_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_slot_id, .out_kind, .out_is_active, .out_error
);
